>>> sv/lgr_pkg.sv
// Shared types, constants and the B3/S23 cell rule for the Life row stream.
// Used by lgr_cell, lgr_out_queue and life_generation_row_stream.
package lgr_pkg;

  localparam int FIELD_W       = 32;
  localparam int ROW_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic advance;
    logic flush;
  } lgr_ctrl_t;

  typedef struct packed {
    logic above;
    logic middle;
    logic incoming;
  } lgr_col_t;

  typedef struct packed {
    logic [FIELD_W-1:0] cells;
    logic               last;
  } lgr_item_t;

  typedef struct packed {
    logic first;
    logic second;
  } lgr_push_t;

  function automatic logic life_next(input logic alive, input logic [7:0] nb);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'd0, nb[i]};
    end
    return (cnt == BIRTH_COUNT) || (alive && (cnt == SURVIVE_COUNT));
  endfunction

endpackage

>>> sv/lgr_cell.sv
// One grid column: holds the column's cells of the two previous rows and
// evaluates the rule for both pending rows. Depends on lgr_pkg.
module lgr_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lgr_pkg::lgr_ctrl_t ctrl,
  input  logic              row_bit,
  input  lgr_pkg::lgr_col_t left,
  input  lgr_pkg::lgr_col_t right,
  output lgr_pkg::lgr_col_t col_out,
  output logic              gen_cur,
  output logic              gen_last
);
  import lgr_pkg::*;

  logic above_r, above_nxt;
  logic mid_r, mid_nxt;

  always_comb begin
    above_nxt = above_r;
    mid_nxt   = mid_r;
    if (ctrl.advance) begin
      if (ctrl.flush) begin
        above_nxt = 1'b0;
        mid_nxt   = 1'b0;
      end else begin
        above_nxt = mid_r;
        mid_nxt   = row_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= 1'b0;
      mid_r   <= 1'b0;
    end else begin
      above_r <= above_nxt;
      mid_r   <= mid_nxt;
    end
  end

  assign col_out = '{above: above_r, middle: mid_r, incoming: row_bit};

  assign gen_cur = life_next(mid_r, {left.above, left.middle, left.incoming,
                                     above_r, row_bit,
                                     right.above, right.middle, right.incoming});

  // bottom row: middle becomes the row above, dead row below
  assign gen_last = life_next(row_bit, {left.middle, left.incoming, 1'b0,
                                        mid_r, 1'b0,
                                        right.middle, right.incoming, 1'b0});

endmodule

>>> sv/lgr_out_queue.sv
// Result queue taking up to two rows per cycle and releasing one.
// Depends on lgr_pkg.
module lgr_out_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lgr_pkg::lgr_push_t            push,
  input  lgr_pkg::lgr_item_t            item_a,
  input  lgr_pkg::lgr_item_t            item_b,
  input  logic                          pop,
  output lgr_pkg::lgr_item_t            head,
  output logic                          not_empty,
  output logic [lgr_pkg::QPTR_W:0]      level
);
  import lgr_pkg::*;

  lgr_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     level_r, level_nxt;
  logic [QPTR_W-1:0]   wr_second;
  logic                do_pop;

  assign do_pop    = pop && (level_r != '0);
  assign wr_second = wr_ptr_r + QPTR_W'(push.first);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.first) + QPTR_W'(push.second);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    level_nxt  = level_r + (QPTR_W+1)'(push.first) + (QPTR_W+1)'(push.second)
                 - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wr_ptr_r] <= item_a;
    end
    if (push.second) begin
      mem_r[wr_second] <= item_b;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign level     = level_r;

endmodule

>>> sv/life_generation_row_stream.sv
// Top level of the streaming Life (B3/S23) generation block: a row of
// column cells feeding a small result queue. Depends on lgr_pkg, lgr_cell
// and lgr_out_queue.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | in_row_cells, in_end_of_frame
//   out     | output    | out_valid/stall  | out_next_row_cells, out_last_row
//
// One row is taken per cycle while in_stall is low; the results it completes are queued for the next cycle.
// The bottom row of a frame yields two results in one cycle through the
// two-write queue, so rate is one row per cycle while out is not stalled.
// rst_n is synchronous: it clears the held rows and empties the queue.
// in_stall rises from the queue fill level alone, once fewer than two
// entries are free.
module life_generation_row_stream #(
  parameter int ROW_WIDTH = lgr_pkg::ROW_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lgr_pkg::FIELD_W-1:0] in_row_cells,
  input  logic                        in_end_of_frame,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lgr_pkg::FIELD_W-1:0] out_next_row_cells,
  output logic                        out_last_row
);
  import lgr_pkg::*;

  localparam int NCELL = (ROW_WIDTH < FIELD_W) ? ROW_WIDTH : FIELD_W;

  logic              in_xfer;
  logic              primed_r, primed_nxt;
  lgr_ctrl_t         ctrl;
  lgr_col_t          col [NCELL+2];
  logic [NCELL-1:0]  gen_cur;
  logic [NCELL-1:0]  gen_last;
  logic [NCELL-1:0]  mid_vec;
  lgr_push_t         push;
  lgr_item_t         item_a, item_b, head;
  logic              q_not_empty;
  logic [QPTR_W:0]   q_level;

  assign in_stall = (q_level > (QPTR_W+1)'(QUEUE_DEPTH - 2));
  assign in_xfer  = in_valid && !in_stall;

  assign ctrl = '{advance: in_xfer, flush: in_end_of_frame};

  always_comb begin
    primed_nxt = primed_r;
    if (in_xfer) begin
      primed_nxt = !in_end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
    end else begin
      primed_r <= primed_nxt;
    end
  end

  assign col[0]       = '0;
  assign col[NCELL+1] = '0;

  for (genvar x = 0; x < NCELL; x++) begin : g_cell
    lgr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .row_bit  (in_row_cells[x]),
      .left     (col[x]),
      .right    (col[x+2]),
      .col_out  (col[x+1]),
      .gen_cur  (gen_cur[x]),
      .gen_last (gen_last[x])
    );
    assign mid_vec[x] = col[x+1].middle;
  end

  assign push   = '{first: in_xfer && primed_r, second: in_xfer && in_end_of_frame};
  assign item_a = '{cells: FIELD_W'(gen_cur), last: 1'b0};
  assign item_b = '{cells: FIELD_W'(gen_last), last: 1'b1};

  lgr_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .item_a    (item_a),
    .item_b    (item_b),
    .pop       (!out_stall),
    .head      (head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  assign out_valid          = q_not_empty;
  assign out_next_row_cells = head.cells;
  assign out_last_row       = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_eof_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_end_of_frame |=> out_valid)
    else $error("bottom row produced no result");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_end_of_frame |=> !primed_r && (mid_vec == '0))
    else $error("frame end did not clear held rows");

  a_empty_rows: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> (mid_vec == '0))
    else $error("held row nonzero with no row held");

endmodule
